@@ rtl/core/rfd_pkg.sv @@
// rfd_pkg: shared types and codes of the frame deframer
// no dependencies; used by the top level and the bench
package rfd_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 8;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_CMD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_RSP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_NTC = 3'd4;

	// frame status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_END  = 2'd1;
	localparam logic [1:0] ST_BAD_SUM  = 2'd2;
	localparam logic [1:0] ST_BAD_TYPE = 2'd3;

	// reset values of the configuration registers
	localparam logic [7:0] HEADER_RST   = 8'hBB;
	localparam logic [7:0] END_RST      = 8'h7E;
	localparam logic [7:0] TYPE_CMD_RST = 8'h00;
	localparam logic [7:0] TYPE_RSP_RST = 8'h01;
	localparam logic [7:0] TYPE_NTC_RST = 8'h02;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        last;
		logic [7:0]  frame_type;
		logic [7:0]  command;
		logic [15:0] param_length;
		logic [1:0]  status;
	} result_t;

endpackage

@@ rtl/core/rfd_if.sv @@
// rfd_if: valid/ready channels of the frame deframer
// rfd_byte_if carries received bytes, rfd_result_if carries deframed results
interface rfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface rfd_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        last;
	logic [7:0]  frame_type;
	logic [7:0]  command;
	logic [15:0] param_length;
	logic [1:0]  status;

	modport source (output valid, output data_byte, output last, output frame_type,
		output command, output param_length, output status, input ready);
	modport sink (input valid, input data_byte, input last, input frame_type,
		input command, input param_length, input status, output ready);
endinterface

@@ rtl/core/rfid_frame_deframer.sv @@
// rfid_frame_deframer: byte-stream deframer with an 8-bit modulo-sum checksum
// depends on rfd_pkg and the channel interfaces in rfd_if.sv
//
// rx takes one received byte per transaction. Bytes are dropped until the
// header byte; then type, command and a big-endian 16-bit length follow,
// then the parameter bytes, a checksum byte and the end marker. Each
// parameter byte leaves on frame as one transaction with last low; the end
// marker gives one transaction with last high and the frame status
// (bad end marker before checksum mismatch before unknown type). Header,
// type, command, length and checksum bytes give no transaction.
// A byte is registered in the input register on acceptance and decoded into
// the result register, which drives frame. The decoder handles one byte per
// cycle while frame does not stall: throughput is one byte per cycle, set by
// the update of the frame state register on each decoded byte. When frame
// stalls, the result register holds and one more byte can wait in the input
// register; rx.ready drops only when both are full. Reset returns the block
// to hunting and loads the default header 0xBB, end marker 0x7E and type codes
// 0, 1 and 2. The cfg port writes one register per cycle; unknown indexes are
// ignored. The user must write only while no frame is in flight; not enforced.
module rfid_frame_deframer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rfd_pkg::CFG_DATA_W-1:0] cfg_data,
	rfd_byte_if.sink                      rx,
	rfd_result_if.source                  frame
);
	import rfd_pkg::*;

	localparam logic [2:0] PH_HUNT   = 3'd0;
	localparam logic [2:0] PH_TYPE   = 3'd1;
	localparam logic [2:0] PH_CMD    = 3'd2;
	localparam logic [2:0] PH_LEN_HI = 3'd3;
	localparam logic [2:0] PH_LEN_LO = 3'd4;
	localparam logic [2:0] PH_PARAM  = 3'd5;
	localparam logic [2:0] PH_CHECK  = 3'd6;
	localparam logic [2:0] PH_END    = 3'd7;

	logic [7:0]  header_q, end_q, type_cmd_q, type_rsp_q, type_ntc_q;
	logic [2:0]  phase_q, phase_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  command_q, command_d;
	logic [15:0] length_q, length_d;
	logic [15:0] remain_q, remain_d;
	logic [7:0]  sum_q, sum_d;
	logic        sum_ok_q, sum_ok_d;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	result_t     res_s2, res_d;
	logic        res_hit;
	logic        adv;
	logic        fire;
	logic [15:0] remain_dec;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q   <= HEADER_RST;
			end_q      <= END_RST;
			type_cmd_q <= TYPE_CMD_RST;
			type_rsp_q <= TYPE_RSP_RST;
			type_ntc_q <= TYPE_NTC_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HEADER:   header_q   <= cfg_data;
				CFG_END:      end_q      <= cfg_data;
				CFG_TYPE_CMD: type_cmd_q <= cfg_data;
				CFG_TYPE_RSP: type_rsp_q <= cfg_data;
				CFG_TYPE_NTC: type_ntc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv      = !valid_s2 || frame.ready;
	assign fire     = valid_s1 && adv;
	assign rx.ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	assign remain_dec = remain_q - 16'd1;

	// frame decoder
	always_comb begin
		phase_d   = phase_q;
		type_d    = type_q;
		command_d = command_q;
		length_d  = length_q;
		remain_d  = remain_q;
		sum_d     = sum_q;
		sum_ok_d  = sum_ok_q;
		res_hit   = 1'b0;
		res_d     = '0;
		case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == header_q) begin
					phase_d = PH_TYPE;
				end
			end
			PH_TYPE: begin
				type_d  = byte_s1;
				sum_d   = byte_s1;
				phase_d = PH_CMD;
			end
			PH_CMD: begin
				command_d = byte_s1;
				sum_d     = sum_q + byte_s1;
				phase_d   = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				length_d = {byte_s1, 8'h00};
				sum_d    = sum_q + byte_s1;
				phase_d  = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				length_d = {length_q[15:8], byte_s1};
				remain_d = {length_q[15:8], byte_s1};
				sum_d    = sum_q + byte_s1;
				phase_d  = ({length_q[15:8], byte_s1} != 16'd0) ? PH_PARAM : PH_CHECK;
			end
			PH_PARAM: begin
				sum_d    = sum_q + byte_s1;
				remain_d = remain_dec;
				if (remain_dec == 16'd0) begin
					phase_d = PH_CHECK;
				end
				res_hit         = 1'b1;
				res_d.data_byte = byte_s1;
				res_d.status    = ST_OK;
			end
			PH_CHECK: begin
				sum_ok_d = (byte_s1 == sum_q);
				phase_d  = PH_END;
			end
			PH_END: begin
				res_hit    = 1'b1;
				res_d.last = 1'b1;
				if (byte_s1 != end_q) begin
					res_d.status = ST_BAD_END;
				end else if (!sum_ok_q) begin
					res_d.status = ST_BAD_SUM;
				end else if (type_q != type_cmd_q && type_q != type_rsp_q &&
						type_q != type_ntc_q) begin
					res_d.status = ST_BAD_TYPE;
				end else begin
					res_d.status = ST_OK;
				end
				phase_d = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
		res_d.frame_type   = type_q;
		res_d.command      = command_q;
		res_d.param_length = length_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			type_q    <= '0;
			command_q <= '0;
			length_q  <= '0;
			remain_q  <= '0;
			sum_q     <= '0;
			sum_ok_q  <= 1'b0;
		end else if (fire) begin
			phase_q   <= phase_d;
			type_q    <= type_d;
			command_q <= command_d;
			length_q  <= length_d;
			remain_q  <= remain_d;
			sum_q     <= sum_d;
			sum_ok_q  <= sum_ok_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= fire && res_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_hit) begin
			res_s2 <= res_d;
		end
	end

	assign frame.valid        = valid_s2;
	assign frame.data_byte    = res_s2.data_byte;
	assign frame.last         = res_s2.last;
	assign frame.frame_type   = res_s2.frame_type;
	assign frame.command      = res_s2.command;
	assign frame.param_length = res_s2.param_length;
	assign frame.status       = res_s2.status;

	// parameter phase always has bytes left to take
	a_param_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PARAM |-> remain_q != 16'd0)
		else $error("parameter phase with zero remaining count");

	// only parameter and end-marker bytes produce a result
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && phase_q != PH_PARAM && phase_q != PH_END) |=> !valid_s2)
		else $error("result from a byte that carries none");

	a_last_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.last) |-> res_s2.data_byte == 8'd0)
		else $error("last result carries a data byte");

	a_param_status: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.last) |-> res_s2.status == ST_OK)
		else $error("parameter result carries a status");

	// an end marker always sends the decoder back to hunting
	a_end_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && phase_q == PH_END) |=> phase_q == PH_HUNT)
		else $error("decoder did not return to hunting after end marker");

endmodule

@@ bench/tb_rfid_frame_deframer.sv @@
// tb_rfid_frame_deframer: self-checking bench for the byte-stream frame deframer
// depends on rfd_pkg, the channel interfaces of rfd_if.sv and the rfid_frame_deframer top
// a frame predictor runs on every accepted byte; a scoreboard class checks each result
module tb_rfid_frame_deframer;
	import rfd_pkg::*;

	localparam int unsigned PHASE_ITEMS  = 200;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned HOLD_CYCLES  = 80;
	localparam int unsigned PRINT_LIMIT  = 40;

	// one past the last register: writes here must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_TYPE_NTC + 1'b1;

	// short directed run under the reset register values
	localparam logic [7:0] DIRECTED_SEQ [31] = '{
		8'h00, 8'hFF,
		HEADER_RST, 8'h00, 8'hFF, 8'h00, 8'h01, HEADER_RST, 8'hBB, END_RST,
		HEADER_RST, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, END_RST,
		HEADER_RST, 8'h01, 8'h80, 8'h00, 8'h00, 8'h81, 8'h00,
		HEADER_RST, 8'h80, 8'h00, 8'h00, 8'h00, 8'h80, END_RST
	};

	typedef enum logic [2:0] {
		PH_HUNT, PH_TYPE, PH_CMD, PH_LEN_HI, PH_LEN_LO, PH_PARAM, PH_CHECK, PH_END
	} frame_phase_e;

	class frame_checker;
		logic [7:0]   hdr, end_mark, code_cmd, code_rsp, code_ntc;
		frame_phase_e phase;
		logic [7:0]   type_q, cmd_q, sum;
		logic [15:0]  len_q, remaining;
		logic         sum_ok;
		result_t      pending[$];
		int unsigned  mismatches, results_checked;
		int unsigned  frames_by_status[4];

		function new();
			hdr = HEADER_RST;
			end_mark = END_RST;
			code_cmd = TYPE_CMD_RST;
			code_rsp = TYPE_RSP_RST;
			code_ntc = TYPE_NTC_RST;
			phase = PH_HUNT;
			type_q = '0;
			cmd_q = '0;
			sum = '0;
			len_q = '0;
			remaining = '0;
			sum_ok = 1'b0;
			mismatches = 0;
			results_checked = 0;
			foreach (frames_by_status[i]) frames_by_status[i] = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
			case (idx)
				CFG_HEADER:   hdr = val;
				CFG_END:      end_mark = val;
				CFG_TYPE_CMD: code_cmd = val;
				CFG_TYPE_RSP: code_rsp = val;
				CFG_TYPE_NTC: code_ntc = val;
				default: ;
			endcase
		endfunction

		// advance the frame state by one accepted byte and queue any result
		function void take_byte(logic [7:0] b);
			result_t r;
			r.data_byte = b;
			r.last = 1'b0;
			r.status = ST_OK;
			case (phase)
				PH_HUNT: begin
					if (b == hdr) phase = PH_TYPE;
				end
				PH_TYPE: begin
					type_q = b;
					sum = b;
					phase = PH_CMD;
				end
				PH_CMD: begin
					cmd_q = b;
					sum = sum + b;
					phase = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					len_q = {b, 8'h00};
					sum = sum + b;
					phase = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len_q[7:0] = b;
					sum = sum + b;
					remaining = len_q;
					phase = (len_q != 0) ? PH_PARAM : PH_CHECK;
				end
				PH_PARAM: begin
					sum = sum + b;
					remaining = remaining - 1'b1;
					if (remaining == 0) phase = PH_CHECK;
				end
				PH_CHECK: begin
					sum_ok = (b == sum);
					phase = PH_END;
				end
				default: begin
					r.data_byte = '0;
					r.last = 1'b1;
					if (b != end_mark) r.status = ST_BAD_END;
					else if (!sum_ok) r.status = ST_BAD_SUM;
					else if (type_q != code_cmd && type_q != code_rsp && type_q != code_ntc)
						r.status = ST_BAD_TYPE;
					phase = PH_HUNT;
				end
			endcase
			// param bytes and the end-marker byte each give one result
			if (r.last || (phase == PH_PARAM || phase == PH_CHECK) && r.data_byte == b
					&& remaining != len_q) begin
				r.frame_type = type_q;
				r.command = cmd_q;
				r.param_length = len_q;
				pending.push_back(r);
			end
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= PRINT_LIMIT) $display("mismatch at %0t: %s", $time, msg);
		endtask

		task check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				report($sformatf("result %h with nothing expected", got));
				return;
			end
			want = pending.pop_front();
			results_checked++;
			if (got.data_byte !== want.data_byte)
				report($sformatf("data_byte %h, expected %h", got.data_byte, want.data_byte));
			if (got.last !== want.last)
				report($sformatf("last %b, expected %b", got.last, want.last));
			if (got.frame_type !== want.frame_type)
				report($sformatf("frame_type %h, expected %h", got.frame_type, want.frame_type));
			if (got.command !== want.command)
				report($sformatf("command %h, expected %h", got.command, want.command));
			if (got.param_length !== want.param_length)
				report($sformatf("param_length %h, expected %h", got.param_length,
					want.param_length));
			if (got.status !== want.status)
				report($sformatf("status %0d, expected %0d", got.status, want.status));
			if (want.last) frames_by_status[want.status]++;
		endtask

		task close_out();
			if (pending.size() != 0)
				report($sformatf("%0d expected results never arrived", pending.size()));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rfd_byte_if   rx_if ();
	rfd_result_if res_if ();

	rfid_frame_deframer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx        (rx_if),
		.frame     (res_if)
	);

	frame_checker sb = new();

	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	bit          hold_req;
	int unsigned holds_done;
	int unsigned bytes_sent;
	int unsigned settings_applied;
	int unsigned quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// result receiver: random stalls, plus one long hold-off on request
	initial begin
		res_if.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				holds_done++;
			end else begin
				res_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			sb.check_result('{res_if.data_byte, res_if.last, res_if.frame_type,
				res_if.command, res_if.param_length, res_if.status});
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", quiet_cycles);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// offer one byte, hold it until the transaction, then feed the predictor
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			rx_if.valid <= 1'b0;
			@(negedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		@(posedge clk);
		while (!rx_if.ready) @(posedge clk);
		sb.take_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	// finish any open frame, keeping lengths short
	task automatic resync();
		while (sb.phase != PH_HUNT) begin
			case (sb.phase)
				PH_LEN_HI: send_byte(8'h00);
				PH_LEN_LO: send_byte(8'($urandom_range(0, 3)));
				default:   send_byte(8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic send_frame(input logic [15:0] forced_len, input bit use_forced);
		logic [7:0]  fb[$];
		logic [7:0]  t, c, sum, pb;
		logic [15:0] len;
		int unsigned roll, nparam;
		roll = $urandom_range(0, 9);
		if (roll < 3) t = sb.code_cmd;
		else if (roll < 5) t = sb.code_rsp;
		else if (roll < 7) t = sb.code_ntc;
		else t = 8'($urandom_range(0, 255));
		c = 8'($urandom_range(0, 255));
		roll = $urandom_range(0, 99);
		if (use_forced) len = forced_len;
		else if (roll < 80) len = 16'($urandom_range(0, 8));
		else if (roll < 96) len = 16'($urandom_range(9, 40));
		else len = 16'($urandom_range(256, 316));
		fb = '{sb.hdr, t, c, len[15:8], len[7:0]};
		sum = t + c + len[15:8] + len[7:0];
		nparam = 32'(len);
		// a length field that may not match the bytes that follow
		if (!use_forced && $urandom_range(0, 99) < 6) nparam = $urandom_range(0, len + 2);
		repeat (nparam) begin
			pb = ($urandom_range(0, 19) == 0) ? sb.hdr : 8'($urandom_range(0, 255));
			fb.push_back(pb);
			sum = sum + pb;
		end
		fb.push_back(($urandom_range(0, 99) < 85) ? sum : sum ^ 8'($urandom_range(1, 255)));
		fb.push_back(($urandom_range(0, 99) < 85) ? sb.end_mark
			: sb.end_mark ^ 8'($urandom_range(1, 255)));
		if (!use_forced && $urandom_range(0, 99) < 5) fb = fb[0:$urandom_range(1, fb.size() - 2)];
		foreach (fb[i]) send_byte(fb[i]);
	endtask

	// bring the block to idle: no frame open, nothing outstanding
	task automatic settle();
		resync();
		rx_if.valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic apply_setting(input int p);
		logic [7:0] v[5];
		case (p)
			1: v = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80};
			2: v = '{8'hFF, 8'h00, 8'h55, 8'hAA, 8'h55};
			5: v = '{HEADER_RST, END_RST, TYPE_CMD_RST, TYPE_RSP_RST, TYPE_NTC_RST};
			default: foreach (v[i]) v[i] = 8'($urandom_range(0, 255));
		endcase
		cfg_write(CFG_HEADER, v[0]);
		cfg_write(CFG_END, v[1]);
		cfg_write(CFG_TYPE_CMD, v[2]);
		cfg_write(CFG_TYPE_RSP, v[3]);
		cfg_write(CFG_TYPE_NTC, v[4]);
		cfg_write(CFG_SPARE, 8'($urandom_range(0, 255)));
		cfg_we <= 1'b0;
		settings_applied++;
	endtask

	initial begin
		int unsigned phase_start;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		rx_if.valid <= 1'b0;
		rx_if.rx_byte <= '0;
		tx_idle_pct = 8;
		rx_idle_pct = 59;
		hold_req = 1'b0;
		holds_done = 0;
		bytes_sent = 0;
		settings_applied = 0;
		quiet_cycles = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED_SEQ[i]) send_byte(DIRECTED_SEQ[i]);

		for (int p = 0; p < 6; p++) begin
			if (p > 0) begin
				settle();
				apply_setting(p);
			end
			case (p / 2)
				0: begin
					tx_idle_pct = 8;
					rx_idle_pct = 59;
				end
				1: begin
					tx_idle_pct = 59;
					rx_idle_pct = 8;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			// long receiver hold-off while bytes keep coming
			if (p == 3) hold_req = 1'b1;
			phase_start = bytes_sent;
			// length whose count borrows across the byte boundary
			if (p == 5) send_frame(16'h0100, 1'b1);
			while (bytes_sent - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 15) send_noise();
				resync();
				send_frame(16'h0000, 1'b0);
			end
		end
		settle();
		sb.close_out();

		$display("covered %0d bytes in, %0d results checked, %0d register settings, %0d hold-offs",
			bytes_sent, sb.results_checked, settings_applied, holds_done);
		$display("frame ends: ok %0d, bad end %0d, bad checksum %0d, unknown type %0d",
			sb.frames_by_status[ST_OK], sb.frames_by_status[ST_BAD_END],
			sb.frames_by_status[ST_BAD_SUM], sb.frames_by_status[ST_BAD_TYPE]);
		if (sb.mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/rfd_pkg.sv
rtl/core/rfd_if.sv
rtl/core/rfid_frame_deframer.sv
bench/tb_rfid_frame_deframer.sv
